// ----- rtl/usb_cable_hotplug_detector_defines.svh -----
// assertion macros for the usb cable hotplug detector
// no dependencies; expects clk and rst_n in the including scope
`ifndef USB_CABLE_HOTPLUG_DETECTOR_DEFINES_SVH
`define USB_CABLE_HOTPLUG_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define UCHD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define UCHD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define UCHD_ASSERT_IMPL(label, ante, cons, msg)
`define UCHD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- rtl/uchd_pkg.sv -----
// types and codes for the usb cable hotplug detector
// no dependencies
package uchd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_PROBE    = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE          = 3'd0,
    EV_USB_ADD       = 3'd1,
    EV_USB_REMOVE    = 3'd2,
    EV_POWER_ADD     = 3'd3,
    EV_POWER_REMOVE  = 3'd4,
    EV_SUSPEND_POWER = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE_TICKS   = 2'd0,
    REG_PROBE_ROUNDS     = 2'd1,
    REG_USB_VOTES_NEEDED = 2'd2,
    REG_SUSPEND_TICKS    = 2'd3
  } reg_index_t;

  localparam logic [7:0]  DEBOUNCE_TICKS_RST   = 8'd50;
  localparam logic [2:0]  PROBE_ROUNDS_RST     = 3'd3;
  localparam logic [2:0]  USB_VOTES_NEEDED_RST = 3'd2;
  localparam logic [15:0] SUSPEND_TICKS_RST    = 16'd300;
  localparam logic [2:0]  VOTES_MAX            = 3'd7;

  typedef struct packed {
    logic pin_level;
    logic bus_activity;
    logic probe_valid;
    logic probe_bus_event;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic       cable_connected;
    logic       usb_mode;
    logic       switch_drive;
    logic       probe_request;
    logic       busy_res;
    logic       power_only;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] wdata;
  } cfg_item_t;

endpackage

// ----- rtl/uchd_if.sv -----
// valid/ready channel interfaces for the usb cable hotplug detector
// depends on uchd_pkg
interface uchd_in_if import uchd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface uchd_out_if import uchd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface uchd_cfg_if import uchd_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/usb_cable_hotplug_detector.sv -----
// usb cable hotplug detector: one registered result beat per accepted input beat
// 1 beat per cycle while skid is empty; state updates once per accepted beat
// output register plus one skid entry, so input is taken while a result waits
// cfg port always ready, takes one write per cycle
// synchronous active-low reset: registers to defaults, all state cleared
// depends on uchd_pkg, uchd_if.sv and usb_cable_hotplug_detector_defines.svh
`include "usb_cable_hotplug_detector_defines.svh"

module usb_cable_hotplug_detector import uchd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  uchd_in_if.sink     in_ch,
  uchd_out_if.source  out_ch,
  uchd_cfg_if.sink    cfg_ch
);

  logic [7:0]  debounce_ticks_r;
  logic [2:0]  probe_rounds_r;
  logic [2:0]  usb_votes_needed_r;
  logic [15:0] suspend_ticks_r;

  phase_t      phase_r, phase_nxt;
  logic        cable_state_r, cable_state_nxt;
  logic        protocol_usb_r, protocol_usb_nxt;
  logic        old_protocol_usb_r, old_protocol_usb_nxt;
  logic        stable_level_r, stable_level_nxt;
  logic [7:0]  stable_count_r, stable_count_nxt;
  logic [2:0]  probe_index_r, probe_index_nxt;
  logic [2:0]  usb_votes_r, usb_votes_nxt;
  logic        last_probe_usb_r, last_probe_usb_nxt;
  logic        activity_seen_r, activity_seen_nxt;
  logic        activity_history_r, activity_history_nxt;
  logic        watchdog_running_r, watchdog_running_nxt;
  logic [15:0] watchdog_count_r, watchdog_count_nxt;
  logic        switch_level_r, switch_level_nxt;
  event_t      last_event_r, last_event_nxt;

  event_t      ev;
  logic        req;
  logic [15:0] period;
  logic [2:0]  rounds;
  out_item_t   res;

  logic        out_valid_r, skid_valid_r;
  out_item_t   out_data_r, skid_data_r;
  logic        in_fire, out_fire, cfg_fire;
  in_item_t    beat;

  assign beat         = in_ch.data;
  assign in_ch.ready  = !skid_valid_r;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign out_fire     = out_valid_r && out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  assign period = (suspend_ticks_r == 16'd0) ? 16'd1 : suspend_ticks_r;
  assign rounds = (probe_rounds_r == 3'd0) ? 3'd1 : probe_rounds_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r   <= DEBOUNCE_TICKS_RST;
      probe_rounds_r     <= PROBE_ROUNDS_RST;
      usb_votes_needed_r <= USB_VOTES_NEEDED_RST;
      suspend_ticks_r    <= SUSPEND_TICKS_RST;
    end else if (cfg_fire) begin
      unique case (reg_index_t'(cfg_ch.data.index))
        REG_DEBOUNCE_TICKS:   debounce_ticks_r   <= cfg_ch.data.wdata[7:0];
        REG_PROBE_ROUNDS:     probe_rounds_r     <= cfg_ch.data.wdata[2:0];
        REG_USB_VOTES_NEEDED: usb_votes_needed_r <= cfg_ch.data.wdata[2:0];
        REG_SUSPEND_TICKS:    suspend_ticks_r    <= cfg_ch.data.wdata;
        default: ;
      endcase
    end
  end

  // next state: watchdog first, then detection
  always_comb begin
    phase_nxt            = phase_r;
    cable_state_nxt      = cable_state_r;
    protocol_usb_nxt     = protocol_usb_r;
    old_protocol_usb_nxt = old_protocol_usb_r;
    stable_level_nxt     = stable_level_r;
    stable_count_nxt     = stable_count_r;
    probe_index_nxt      = probe_index_r;
    usb_votes_nxt        = usb_votes_r;
    last_probe_usb_nxt   = last_probe_usb_r;
    activity_seen_nxt    = activity_seen_r;
    activity_history_nxt = activity_history_r;
    watchdog_running_nxt = watchdog_running_r;
    watchdog_count_nxt   = watchdog_count_r;
    switch_level_nxt     = switch_level_r;
    last_event_nxt       = last_event_r;
    ev                   = EV_NONE;
    req                  = 1'b0;

    if (watchdog_running_r) begin
      if (beat.bus_activity) activity_seen_nxt = 1'b1;
      if ({1'b0, watchdog_count_r} + 17'd1 >= {1'b0, period}) begin
        watchdog_count_nxt = 16'd0;
        if (activity_seen_nxt) begin
          activity_history_nxt = 1'b1;
          activity_seen_nxt    = 1'b0;
        end else if (activity_history_nxt) begin
          activity_history_nxt = 1'b0;
          protocol_usb_nxt     = 1'b0;
          watchdog_running_nxt = 1'b0;
          activity_seen_nxt    = 1'b0;
        end
      end else begin
        watchdog_count_nxt = watchdog_count_r + 16'd1;
      end
    end

    unique case (phase_r)
      PH_DEBOUNCE: begin
        if (beat.pin_level != stable_level_r) begin
          stable_level_nxt = beat.pin_level;
          stable_count_nxt = 8'd1;
        end
        if (stable_count_nxt >= debounce_ticks_r) begin
          phase_nxt = PH_IDLE;
          if (cable_state_r) begin
            if (!beat.pin_level) begin
              cable_state_nxt      = 1'b0;
              protocol_usb_nxt     = 1'b0;
              ev                   = old_protocol_usb_r ? EV_USB_REMOVE : EV_POWER_REMOVE;
              old_protocol_usb_nxt = 1'b0;
              watchdog_running_nxt = 1'b0;
              watchdog_count_nxt   = 16'd0;
              activity_seen_nxt    = 1'b0;
              activity_history_nxt = 1'b0;
            end else if (old_protocol_usb_r != protocol_usb_nxt) begin
              ev                   = EV_SUSPEND_POWER;
              old_protocol_usb_nxt = protocol_usb_nxt;
            end
          end else if (beat.pin_level) begin
            cable_state_nxt = 1'b1;
            phase_nxt       = PH_PROBE;
            probe_index_nxt = 3'd0;
            usb_votes_nxt   = 3'd0;
            req             = 1'b1;
          end
        end else begin
          stable_count_nxt = stable_count_nxt + 8'd1;
        end
      end
      PH_PROBE: begin
        if (beat.probe_valid) begin
          last_probe_usb_nxt = beat.probe_bus_event;
          if (beat.probe_bus_event && usb_votes_r != VOTES_MAX) begin
            usb_votes_nxt = usb_votes_r + 3'd1;
          end
          probe_index_nxt = probe_index_r + 3'd1;
          if (probe_index_nxt >= rounds) begin
            phase_nxt = PH_IDLE;
            if (beat.probe_bus_event && usb_votes_nxt >= usb_votes_needed_r) begin
              protocol_usb_nxt     = 1'b1;
              old_protocol_usb_nxt = 1'b1;
              ev                   = EV_USB_ADD;
              watchdog_running_nxt = 1'b1;
              watchdog_count_nxt   = 16'd0;
              activity_seen_nxt    = 1'b0;
            end else begin
              protocol_usb_nxt     = 1'b0;
              old_protocol_usb_nxt = 1'b0;
              ev                   = EV_POWER_ADD;
            end
          end else begin
            req = 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (beat.pin_level != cable_state_r || protocol_usb_nxt != old_protocol_usb_r) begin
          phase_nxt        = PH_DEBOUNCE;
          stable_level_nxt = beat.pin_level;
          stable_count_nxt = 8'd1;
        end
      end
    endcase

    if (ev != EV_NONE) begin
      last_event_nxt = ev;
      if (ev != EV_POWER_ADD) switch_level_nxt = 1'b1;
    end
  end

  // result item
  always_comb begin
    res.event_code      = ev;
    res.cable_connected = cable_state_nxt;
    res.usb_mode        = protocol_usb_nxt;
    res.switch_drive    = switch_level_nxt;
    res.probe_request   = req;
    res.busy_res        = (phase_nxt == PH_DEBOUNCE) || (phase_nxt == PH_PROBE);
    res.power_only      = (last_event_nxt == EV_POWER_ADD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r            <= PH_IDLE;
      cable_state_r      <= 1'b0;
      protocol_usb_r     <= 1'b0;
      old_protocol_usb_r <= 1'b0;
      stable_level_r     <= 1'b0;
      stable_count_r     <= 8'd0;
      probe_index_r      <= 3'd0;
      usb_votes_r        <= 3'd0;
      last_probe_usb_r   <= 1'b0;
      activity_seen_r    <= 1'b0;
      activity_history_r <= 1'b0;
      watchdog_running_r <= 1'b0;
      watchdog_count_r   <= 16'd0;
      switch_level_r     <= 1'b0;
      last_event_r       <= EV_NONE;
    end else if (in_fire) begin
      phase_r            <= phase_nxt;
      cable_state_r      <= cable_state_nxt;
      protocol_usb_r     <= protocol_usb_nxt;
      old_protocol_usb_r <= old_protocol_usb_nxt;
      stable_level_r     <= stable_level_nxt;
      stable_count_r     <= stable_count_nxt;
      probe_index_r      <= probe_index_nxt;
      usb_votes_r        <= usb_votes_nxt;
      last_probe_usb_r   <= last_probe_usb_nxt;
      activity_seen_r    <= activity_seen_nxt;
      activity_history_r <= activity_history_nxt;
      watchdog_running_r <= watchdog_running_nxt;
      watchdog_count_r   <= watchdog_count_nxt;
      switch_level_r     <= switch_level_nxt;
      last_event_r       <= last_event_nxt;
    end
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_fire || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_valid_r) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_fire) begin
        out_data_r <= res;
      end
    end else if (in_fire) begin
      skid_data_r <= res;
    end
  end

  `UCHD_ASSERT_IMPL(a_skid_behind_out, skid_valid_r, out_valid_r, "skid beat without output beat")
  `UCHD_ASSERT_NEXT(a_stall_to_skid, in_fire && out_valid_r && !out_ch.ready, skid_valid_r, "stalled beat lost")
  `UCHD_ASSERT_IMPL(a_probe_needs_cable, phase_r == PH_PROBE, cable_state_r, "probing without cable")
  `UCHD_ASSERT_IMPL(a_watchdog_needs_usb, watchdog_running_r, protocol_usb_r, "watchdog running on non-usb cable")

endmodule

// ----- tb/sv/tb_usb_cable_hotplug_detector.sv -----
// self-checking testbench for usb_cable_hotplug_detector: directed and random hotplug ticks,
// a per-tick predictor of the detector state and a checker on every result beat
// depends on uchd_pkg, uchd_if.sv and the rtl top level
`timescale 1ns / 100ps

module tb_usb_cable_hotplug_detector;
  import uchd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;

  uchd_in_if  in_if();
  uchd_out_if out_if();
  uchd_cfg_if cfg_if();

  usb_cable_hotplug_detector DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // predicted detector state
  phase_t      ph;
  logic        cable_on, proto_usb, proto_usb_old, level_held;
  logic [7:0]  held_count;
  logic [2:0]  probes_done, votes;
  logic        last_vote, traffic_seen, traffic_history, wd_on, switch_q;
  logic [15:0] wd_count;
  event_t      last_ev;
  logic [7:0]  cfg_debounce;
  logic [2:0]  cfg_rounds, cfg_votes;
  logic [15:0] cfg_suspend;

  out_item_t   pending_reports[$];
  out_item_t   want_report;
  int unsigned ticks_sent = 0;
  int unsigned stop_at = 0;
  int          beats_checked = 0;
  int          mismatches = 0;
  int          send_idle_pct = 36;
  int          recv_idle_pct = 81;
  int          stall_cycles = 0;
  int          cycles = 0;
  int          event_tally[6] = '{default: 0};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_prediction();
    ph = PH_IDLE;
    cable_on = 1'b0; proto_usb = 1'b0; proto_usb_old = 1'b0; level_held = 1'b0;
    held_count = '0; probes_done = '0; votes = '0; last_vote = 1'b0;
    traffic_seen = 1'b0; traffic_history = 1'b0; wd_on = 1'b0; wd_count = '0;
    switch_q = 1'b0; last_ev = EV_NONE;
    cfg_debounce = DEBOUNCE_TICKS_RST;
    cfg_rounds = PROBE_ROUNDS_RST;
    cfg_votes = USB_VOTES_NEEDED_RST;
    cfg_suspend = SUSPEND_TICKS_RST;
  endfunction

  function automatic out_item_t predict_tick(input in_item_t it);
    event_t      ev;
    logic        req;
    logic [16:0] period;
    logic [2:0]  rounds;
    logic        is_usb;
    out_item_t   r;
    ev = EV_NONE;
    req = 1'b0;
    // inactivity watchdog runs ahead of detection
    if (wd_on) begin
      period = (cfg_suspend == 16'd0) ? 17'd1 : {1'b0, cfg_suspend};
      if (it.bus_activity) traffic_seen = 1'b1;
      if ({1'b0, wd_count} + 17'd1 >= period) begin
        wd_count = '0;
        if (traffic_seen) begin
          traffic_history = 1'b1;
          traffic_seen = 1'b0;
        end else if (traffic_history) begin
          traffic_history = 1'b0;
          proto_usb = 1'b0;
          wd_on = 1'b0;
          traffic_seen = 1'b0;
        end
      end else begin
        wd_count = wd_count + 16'd1;
      end
    end
    if (ph != PH_DEBOUNCE && ph != PH_PROBE) begin
      ph = PH_IDLE;
      if (it.pin_level != cable_on || proto_usb != proto_usb_old) begin
        ph = PH_DEBOUNCE;
        level_held = it.pin_level;
        held_count = 8'd1;
      end
    end else if (ph == PH_DEBOUNCE) begin
      if (it.pin_level != level_held) begin
        level_held = it.pin_level;
        held_count = 8'd1;
      end
      if (held_count >= cfg_debounce) begin
        ph = PH_IDLE;
        if (cable_on) begin
          if (!it.pin_level) begin
            cable_on = 1'b0;
            proto_usb = 1'b0;
            ev = proto_usb_old ? EV_USB_REMOVE : EV_POWER_REMOVE;
            proto_usb_old = 1'b0;
            wd_on = 1'b0;
            wd_count = '0;
            traffic_seen = 1'b0;
            traffic_history = 1'b0;
          end else if (proto_usb_old != proto_usb) begin
            ev = EV_SUSPEND_POWER;
            proto_usb_old = proto_usb;
          end
        end else if (it.pin_level) begin
          cable_on = 1'b1;
          ph = PH_PROBE;
          probes_done = '0;
          votes = '0;
          req = 1'b1;
        end
      end else begin
        held_count = held_count + 8'd1;
      end
    end else if (it.probe_valid) begin
      rounds = (cfg_rounds == 3'd0) ? 3'd1 : cfg_rounds;
      last_vote = it.probe_bus_event;
      if (it.probe_bus_event && votes < VOTES_MAX) votes = votes + 3'd1;
      probes_done = probes_done + 3'd1;
      if (probes_done >= rounds) begin
        is_usb = last_vote && (votes >= cfg_votes);
        ph = PH_IDLE;
        proto_usb = is_usb;
        proto_usb_old = is_usb;
        if (is_usb) begin
          ev = EV_USB_ADD;
          wd_on = 1'b1;
          wd_count = '0;
          traffic_seen = 1'b0;
        end else begin
          ev = EV_POWER_ADD;
        end
      end else begin
        req = 1'b1;
      end
    end
    if (ev != EV_NONE) begin
      last_ev = ev;
      if (ev != EV_POWER_ADD) switch_q = 1'b1;
    end
    r.event_code = ev;
    r.cable_connected = cable_on;
    r.usb_mode = proto_usb;
    r.switch_drive = switch_q;
    r.probe_request = req;
    r.busy_res = (ph == PH_DEBOUNCE || ph == PH_PROBE);
    r.power_only = (last_ev == EV_POWER_ADD);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] MISMATCH %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [2:0] got, input logic [2:0] want);
    if (got !== want)
      report_mismatch($sformatf("beat %0d %s: got %0d, want %0d",
                                beats_checked, name, got, want));
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("beat %0d arrived with nothing expected", beats_checked));
      end else begin
        want_report = pending_reports.pop_front();
        check_field("event_code", out_if.data.event_code, want_report.event_code);
        check_field("cable_connected", out_if.data.cable_connected, want_report.cable_connected);
        check_field("usb_mode", out_if.data.usb_mode, want_report.usb_mode);
        check_field("switch_drive", out_if.data.switch_drive, want_report.switch_drive);
        check_field("probe_request", out_if.data.probe_request, want_report.probe_request);
        check_field("busy_res", out_if.data.busy_res, want_report.busy_res);
        check_field("power_only", out_if.data.power_only, want_report.power_only);
      end
      beats_checked++;
    end
  end

  // result-side ready, with long holds on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_cycles > 0) begin
        stall_cycles--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d beats still expected",
             cycles, pending_reports.size());
    $display("Mismatches found");
    $finish;
  end

  task automatic send_item(input in_item_t item);
    out_item_t want;
    in_if.valid <= 1'b1;
    in_if.data <= item;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    want = predict_tick(item);
    pending_reports.push_back(want);
    event_tally[want.event_code]++;
    ticks_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{index: idx, wdata: value};
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    case (idx)
      REG_DEBOUNCE_TICKS:   cfg_debounce = value[7:0];
      REG_PROBE_ROUNDS:     cfg_rounds = value[2:0];
      REG_USB_VOTES_NEEDED: cfg_votes = value[2:0];
      REG_SUSPEND_TICKS:    cfg_suspend = value;
      default: ;
    endcase
  endtask

  task automatic load_registers(input logic [7:0] deb, input logic [2:0] rounds,
                                input logic [2:0] needed, input logic [15:0] susp);
    drain_results();
    write_reg(REG_DEBOUNCE_TICKS, {8'd0, deb});
    write_reg(REG_PROBE_ROUNDS, {13'd0, rounds});
    write_reg(REG_USB_VOTES_NEEDED, {13'd0, needed});
    write_reg(REG_SUSPEND_TICKS, susp);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic in_item_t make_tick(input logic pin, input int act_pct, input bit usb_bias);
    in_item_t it;
    it.pin_level = pin;
    if (cfg_debounce <= 8'd12 && $urandom_range(99) < 4) it.pin_level = ~pin;
    it.bus_activity = ($urandom_range(99) < act_pct);
    it.probe_valid = ($urandom_range(99) < ((ph == PH_PROBE) ? 60 : 5));
    it.probe_bus_event = usb_bias ? ($urandom_range(99) < 90) : 1'($urandom_range(1));
    return it;
  endfunction

  // insertion, probe vote, optional traffic then suspend, removal
  task automatic cable_session();
    bit usb_bias;
    int n;
    int cap;
    int period;
    usb_bias = ($urandom_range(2) != 0);
    period = (cfg_suspend == 16'd0) ? 1 : int'(cfg_suspend);
    cap = ($urandom_range(4) == 0) ? $urandom_range(2 * cfg_debounce + 4, 1) : 700;
    for (n = 0; n < cap && ticks_sent < stop_at && !(cable_on && ph == PH_IDLE); n++)
      send_item(make_tick(1'b1, 30, usb_bias));
    if (proto_usb && period <= 64 && $urandom_range(1) == 1) begin
      for (n = 0; n < 2 * period + 2 && ticks_sent < stop_at; n++)
        send_item(make_tick(1'b1, 80, 1'b0));
      cap = 3 * period + 2 * int'(cfg_debounce) + 20;
      for (n = 0; n < cap && ticks_sent < stop_at && (proto_usb_old || ph != PH_IDLE); n++)
        send_item(make_tick(1'b1, 0, 1'b0));
    end
    cap = $urandom_range(8);
    for (n = 0; n < cap && ticks_sent < stop_at; n++)
      send_item(make_tick(1'b1, 50, 1'b0));
    for (n = 0; n < 700 && ticks_sent < stop_at && (cable_on || ph != PH_IDLE); n++)
      send_item(make_tick(1'b0, 30, 1'b0));
    cap = $urandom_range(6);
    for (n = 0; n < cap && ticks_sent < stop_at; n++)
      send_item(make_tick(1'b0, 30, 1'b0));
  endtask

  task automatic run_setting(input logic [7:0] deb, input logic [2:0] rounds,
                             input logic [2:0] needed, input logic [15:0] susp,
                             input int n_items);
    int n;
    int cap;
    load_registers(deb, rounds, needed, susp);
    stop_at = ticks_sent + n_items;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(4) == 0) begin
        // unstructured ticks between sessions
        cap = $urandom_range(30, 8);
        for (n = 0; n < cap && ticks_sent < stop_at; n++)
          send_item(in_item_t'($urandom_range(15)));
      end else begin
        cable_session();
      end
    end
  endtask

  task automatic test_reset_defaults();
    stop_at = ticks_sent + 150;
    cable_session();
  endtask

  task automatic test_directed_events();
    logic [3:0] script [0:25] = '{
      4'b0011, 4'b1000, 4'b0000, 4'b1000, 4'b1000, 4'b1011, 4'b1011,
      4'b1100, 4'b1000, 4'b1000, 4'b1000, 4'b1000,
      4'b0000, 4'b0000,
      4'b1100, 4'b1000, 4'b1010, 4'b1011,
      4'b0000, 4'b0000,
      4'b1000, 4'b1000, 4'b1111, 4'b1111, 4'b0100, 4'b0000
    };
    load_registers(8'd1, 3'd2, 3'd2, 16'd2);
    foreach (script[i]) send_item(in_item_t'(script[i]));
  endtask

  task automatic test_random_settings(input int count, input int items_each);
    int unsigned r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(4, 1);
      run_setting(8'($urandom_range(6, 1)), 3'(r),
                  3'(($urandom_range(3) == 0) ? $urandom_range(7, 1) : $urandom_range(r, 1)),
                  16'($urandom_range(12, 1)), items_each);
    end
  endtask

  task automatic test_slow_extremes();
    run_setting(8'd255, 3'd7, 3'd7, 16'd65535, 560);
  endtask

  task automatic test_fast_extremes();
    run_setting(8'd1, 3'd1, 3'd1, 16'd1, 100);
    run_setting(8'd0, 3'd0, 3'd0, 16'd0, 100);
  endtask

  task automatic test_output_stall();
    load_registers(8'd3, 3'd2, 3'd1, 16'd4);
    stall_cycles = 80;
    stop_at = ticks_sent + 40;
    while (ticks_sent < stop_at) cable_session();
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    clear_prediction();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 36;
    recv_idle_pct = 81;
    test_reset_defaults();
    test_directed_events();
    test_random_settings(4, 125);

    send_idle_pct = 81;
    recv_idle_pct = 36;
    test_slow_extremes();
    test_random_settings(2, 100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_fast_extremes();
    test_output_stall();
    test_random_settings(2, 100);

    drain_results();
    repeat (4) @(posedge clk);
    $display("covered %0d ticks and %0d result beats over default, random and extreme registers",
             ticks_sent, beats_checked);
    $display("events: usb add %0d, usb remove %0d, power add %0d, power remove %0d, suspend %0d",
             event_tally[EV_USB_ADD], event_tally[EV_USB_REMOVE], event_tally[EV_POWER_ADD],
             event_tally[EV_POWER_REMOVE], event_tally[EV_SUSPEND_POWER]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/uchd_pkg.sv
rtl/uchd_if.sv
rtl/usb_cable_hotplug_detector.sv
tb/sv/tb_usb_cable_hotplug_detector.sv
